>>> rtl/core/mhmq_pkg.sv
package mhmq_pkg;

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_REPLACE = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_NOP     = 2'd3
	} req_t;

	localparam int SRC_W = 5;

endpackage

>>> rtl/core/mhmq_fifo.sv
// two-entry queue between request front end and heap engine
module mhmq_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_take,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr_en, rd_en;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && !wr_stall;
	assign rd_en    = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

>>> rtl/core/mhmq_engine.sv
// heap engine: one heap level per step, read of parent/children then compare and write
module mhmq_engine #(
	parameter int MAX_SOURCES = 32,
	parameter int DOC_BITS    = 31,
	parameter int CNT_W       = 6,
	parameter int IDX_W       = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_take,
	input  logic [1:0]               cmd_req,
	input  logic [mhmq_pkg::SRC_W-1:0] cmd_src,
	input  logic [DOC_BITS-1:0]      cmd_doc,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [mhmq_pkg::SRC_W-1:0] res_src,
	output logic [DOC_BITS-1:0]      res_doc,
	output logic [CNT_W-1:0]         res_cnt,
	output logic                     res_err
);
	localparam int SW = mhmq_pkg::SRC_W;
	localparam int EW = SW + DOC_BITS;
	localparam int PW = IDX_W + 1; // 1-based position, up to MAX_SOURCES

	typedef enum logic [2:0] {
		ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_RDB, ST_DN_CMP, ST_DONE
	} state_t;

	// slot p stored at address p-1
	logic [EW-1:0] mem [MAX_SOURCES];
	logic [EW-1:0] rd_a_q, rd_b_q;
	logic [IDX_W-1:0] ra_addr, rb_addr;
	logic            wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [EW-1:0]   wr_data;

	state_t         st_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]  pos_q;
	logic [EW-1:0]  ent_q;
	logic [EW-1:0]  root_q;
	logic           err_q;
	logic           rvalid_q;

	logic [PW:0]    lc, rc;
	logic [EW-1:0]  kid;
	logic [PW-1:0]  kid_pos;
	logic           use_r;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[ra_addr];
		rd_b_q <= mem[rb_addr];
	end

	assign lc      = {pos_q, 1'b0};
	assign rc      = {pos_q, 1'b1};
	assign use_r   = (rc <= {1'b0, cnt_q}) &&
	                 (rd_b_q[DOC_BITS-1:0] < rd_a_q[DOC_BITS-1:0]);
	assign kid     = use_r ? rd_b_q : rd_a_q;
	assign kid_pos = use_r ? rc[PW-1:0] : lc[PW-1:0];

	always_comb begin
		ra_addr = '0;
		rb_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = ent_q;
		case (st_q)
			ST_IDLE: begin
				// last slot fetched ahead for a replace that retires its source
				ra_addr = IDX_W'(cnt_q - 1'b1);
			end
			ST_UP_RD: begin
				ra_addr = IDX_W'((pos_q >> 1) - 1'b1);
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (pos_q > 1 && ent_q[DOC_BITS-1:0] < rd_a_q[DOC_BITS-1:0]) begin
					wr_addr = IDX_W'(pos_q - 1'b1);
					wr_data = rd_a_q;
				end else begin
					wr_addr = IDX_W'(pos_q - 1'b1);
				end
			end
			ST_DN_RDB: begin
				ra_addr = IDX_W'(lc - 1'b1);
				rb_addr = IDX_W'(rc - 1'b1);
			end
			ST_DN_CMP: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(pos_q - 1'b1);
				if (lc <= {1'b0, cnt_q} && kid[DOC_BITS-1:0] < ent_q[DOC_BITS-1:0]) begin
					wr_data = kid;
				end
			end
			default: ;
		endcase
	end

	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid && !(rvalid_q && res_stall);
	assign res_valid = rvalid_q;
	assign res_src   = (cnt_q != 0) ? root_q[EW-1:DOC_BITS] : '0;
	assign res_doc   = (cnt_q != 0) ? root_q[DOC_BITS-1:0] : '0;
	assign res_cnt   = cnt_q;
	assign res_err   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			err_q    <= 1'b0;
			pos_q    <= '0;
			ent_q    <= '0;
			root_q   <= '0;
		end else begin
			if (rvalid_q && !res_stall) begin
				rvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_take) begin
						err_q <= 1'b0;
						case (cmd_req)
							mhmq_pkg::REQ_ADD: begin
								if (cnt_q >= CNT_W'(MAX_SOURCES)) begin
									err_q <= 1'b1;
									st_q  <= ST_DONE;
								end else begin
									cnt_q <= cnt_q + 1'b1;
									pos_q <= PW'(cnt_q + 1'b1);
									ent_q <= {cmd_src, cmd_doc};
									st_q  <= ST_UP_RD;
								end
							end
							mhmq_pkg::REQ_REPLACE: begin
								if (cnt_q == 0) begin
									err_q <= 1'b1;
									st_q  <= ST_DONE;
								end else begin
									pos_q <= PW'(1);
									ent_q <= {root_q[EW-1:DOC_BITS], cmd_doc};
									if (cmd_doc == 0) begin
										st_q <= ST_DN_RD;
									end else begin
										st_q <= ST_DN_RDB;
									end
								end
							end
							mhmq_pkg::REQ_CLEAR: begin
								cnt_q <= '0;
								st_q  <= ST_DONE;
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_UP_RD: st_q <= ST_UP_CMP;
				ST_UP_CMP: begin
					if (pos_q > 1 && ent_q[DOC_BITS-1:0] < rd_a_q[DOC_BITS-1:0]) begin
						pos_q <= pos_q >> 1;
						st_q  <= ST_UP_RD;
					end else begin
						if (pos_q == 1) begin
							root_q <= ent_q;
						end
						st_q <= ST_DONE;
					end
				end
				ST_DN_RD: begin
					// last entry moves to root; heap shrinks
					ent_q <= rd_a_q;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 1) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_DN_RDB;
					end
				end
				ST_DN_RDB: st_q <= ST_DN_CMP;
				ST_DN_CMP: begin
					if (lc <= {1'b0, cnt_q} && kid[DOC_BITS-1:0] < ent_q[DOC_BITS-1:0]) begin
						if (pos_q == 1) begin
							root_q <= kid;
						end
						pos_q <= kid_pos;
						st_q  <= ST_DN_RDB;
					end else begin
						if (pos_q == 1) begin
							root_q <= ent_q;
						end
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rvalid_q <= 1'b1;
					st_q     <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/min_heap_merge_queue.sv
// Min-heap merge queue for k-way merging of sorted document streams.
// Input channel (valid/stall): req_type, source_index, doc_value.
//   add (0) pushes an entry and bubbles it up; replace (1) rewrites the
//   root doc id, doc 0 retires the source (last entry moves up, count
//   drops) and the root sifts down; clear (2) empties the heap.
// Output channel (valid/stall): one word per request with the root entry,
//   entry_count, is_empty and req_error (add on full / replace on empty).
// A two-word queue sits in front of the heap engine so requests keep
// landing while the engine walks the tree.
// Clear, the unused code and an ignored request go straight to the result
// word; an add or a replace walks the tree one level at a time, and a
// replace that retires its source first moves the last entry to the root.
// The engine works one word at a time; each level costs a registered read
// of the heap memory plus a compare-and-write.
// Reset clears the count and the queue; heap memory is not cleared, only
// data from occupied slots is ever used.
// A stalled result word holds; the engine takes no new request until the
// pending result is taken.
module min_heap_merge_queue #(
	parameter int MAX_SOURCES = 32,
	parameter int DOC_BITS    = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [mhmq_pkg::SRC_W-1:0] source_index,
	input  logic [DOC_BITS-1:0]       doc_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mhmq_pkg::SRC_W-1:0] top_source,
	output logic [DOC_BITS-1:0]       top_doc,
	output logic [$clog2(MAX_SOURCES+1)-1:0] entry_count,
	output logic                      is_empty,
	output logic                      req_error
);
	localparam int CNT_W = $clog2(MAX_SOURCES + 1);
	localparam int IDX_W = $clog2(MAX_SOURCES);
	localparam int QW    = 2 + mhmq_pkg::SRC_W + DOC_BITS;

	logic          q_valid, q_take;
	logic [QW-1:0] q_data;

	mhmq_fifo #(.WIDTH(QW)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_stall (in_stall),
		.wr_data  ({req_type, source_index, doc_value}),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_data  (q_data)
	);

	mhmq_engine #(
		.MAX_SOURCES (MAX_SOURCES),
		.DOC_BITS    (DOC_BITS),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_take  (q_take),
		.cmd_req   (q_data[QW-1 -: 2]),
		.cmd_src   (q_data[DOC_BITS +: mhmq_pkg::SRC_W]),
		.cmd_doc   (q_data[DOC_BITS-1:0]),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res_src   (top_source),
		.res_doc   (top_doc),
		.res_cnt   (entry_count),
		.res_err   (req_error)
	);

	assign is_empty = (entry_count == '0);
endmodule

>>> verif/min_heap_merge_queue_test.sv
module min_heap_merge_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 32;
	localparam int DBITS = 31;
	localparam int SRC_W = mhmq_pkg::SRC_W;
	localparam int N_RANDOM = 1200;
	localparam longint CYCLE_LIMIT = 400000;

	// One result word of the heap: root entry plus status flags.
	typedef struct packed {
		logic [SRC_W-1:0] src;
		logic [DBITS-1:0] doc;
		logic [5:0]       cnt;
		logic             empty;
		logic             err;
	} top_word_t;

	// Scoreboard: owns a private copy of the heap and the queue of root words
	// that the block still owes us.
	class heap_scoreboard;
		logic [SRC_W-1:0] h_src [1:DEPTH];
		logic [DBITS-1:0] h_doc [1:DEPTH];
		int               h_cnt;
		top_word_t        owed_tops[$];
		int               mismatches;
		int               words_checked;

		function void clear_heap();
			h_cnt = 0;
		endfunction

		function void bubble_up();
			int               i;
			logic [SRC_W-1:0] s;
			logic [DBITS-1:0] d;
			i = h_cnt;
			s = h_src[i];
			d = h_doc[i];
			while (i > 1 && d < h_doc[i/2]) begin
				h_src[i] = h_src[i/2];
				h_doc[i] = h_doc[i/2];
				i = i / 2;
			end
			h_src[i] = s;
			h_doc[i] = d;
		endfunction

		function void sift_down();
			int               i;
			int               c;
			logic [SRC_W-1:0] s;
			logic [DBITS-1:0] d;
			i = 1;
			s = h_src[1];
			d = h_doc[1];
			forever begin
				c = 2 * i;
				if (c > h_cnt)
					break;
				// right child only wins when strictly smaller
				if (c + 1 <= h_cnt && h_doc[c+1] < h_doc[c])
					c = c + 1;
				if (!(h_doc[c] < d))
					break;
				h_src[i] = h_src[c];
				h_doc[i] = h_doc[c];
				i = c;
			end
			h_src[i] = s;
			h_doc[i] = d;
		endfunction

		// Apply one accepted request and queue the root word it should produce.
		function void note_request(logic [1:0] rq, logic [SRC_W-1:0] s,
			logic [DBITS-1:0] d);
			top_word_t w;
			logic      err;
			err = 1'b0;
			case (rq)
				mhmq_pkg::REQ_ADD: begin
					if (h_cnt >= DEPTH) begin
						err = 1'b1;
					end else begin
						h_cnt++;
						h_src[h_cnt] = s;
						h_doc[h_cnt] = d;
						bubble_up();
					end
				end
				mhmq_pkg::REQ_REPLACE: begin
					if (h_cnt == 0) begin
						err = 1'b1;
					end else begin
						h_doc[1] = d;
						if (d == '0) begin
							// source exhausted: bottom entry takes the root
							h_src[1] = h_src[h_cnt];
							h_doc[1] = h_doc[h_cnt];
							h_cnt--;
						end
						if (h_cnt > 0)
							sift_down();
					end
				end
				mhmq_pkg::REQ_CLEAR: h_cnt = 0;
				default: ;
			endcase
			w.src = (h_cnt > 0) ? h_src[1] : '0;
			w.doc = (h_cnt > 0) ? h_doc[1] : '0;
			w.cnt = h_cnt[5:0];
			w.empty = (h_cnt == 0);
			w.err = err;
			owed_tops.push_back(w);
		endfunction

		function void check_word(top_word_t got);
			top_word_t exp;
			words_checked++;
			if (owed_tops.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result word src=%0d doc=%0d cnt=%0d",
						got.src, got.doc, got.cnt);
				return;
			end
			exp = owed_tops.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: word %0d exp src=%0d doc=%0d cnt=%0d emp=%0b err=%0b",
						words_checked, exp.src, exp.doc, exp.cnt, exp.empty, exp.err);
					$display("       got src=%0d doc=%0d cnt=%0d emp=%0b err=%0b",
						got.src, got.doc, got.cnt, got.empty, got.err);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [1:0]             req_type;
	logic [SRC_W-1:0]       source_index;
	logic [DBITS-1:0]       doc_value;
	logic                   out_valid;
	logic                   out_stall;
	logic [SRC_W-1:0]       top_source;
	logic [DBITS-1:0]       top_doc;
	logic [5:0]             entry_count;
	logic                   is_empty;
	logic                   req_error;

	heap_scoreboard sb;
	longint         cycle_no;
	bit             calm_phase;   // no idling on either side near the end
	int             n_sent;
	int             n_errs_seen;

	min_heap_merge_queue #(
		.MAX_SOURCES(DEPTH),
		.DOC_BITS(DBITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.source_index(source_index),
		.doc_value(doc_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.top_source(top_source),
		.top_doc(top_doc),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.req_error(req_error)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Watchdog on a cycle counter.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("ERROR: timeout at cycle %0d", cycle_no);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: sample handshake at the edge, then pick next stall level.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				sb.check_word('{top_source, top_doc, entry_count, is_empty, req_error});
				if (req_error)
					n_errs_seen++;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Present one request word and hold it until accepted; optional gap first.
	task automatic send_req(logic [1:0] rq, logic [SRC_W-1:0] s, logic [DBITS-1:0] d);
		int gap;
		if (!calm_phase && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		source_index <= s;
		doc_value <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(rq, s, d);
		n_sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		go_idle();
		while (sb.owed_tops.size() != 0)
			@(posedge clk);
	endtask

	// Random doc ids: mostly a narrow range so ties and equal-id ordering occur.
	function automatic logic [DBITS-1:0] pick_doc();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return DBITS'($urandom);
			2, 3: return DBITS'($urandom_range(0, 3));
			default: return DBITS'($urandom_range(1, 60));
		endcase
	endfunction

	initial begin
		int         k;
		int         r;
		logic [1:0] rq;
		sb = new();
		sb.clear_heap();
		sb.mismatches = 0;
		sb.words_checked = 0;
		cycle_no = 0;
		calm_phase = 1'b0;
		n_sent = 0;
		n_errs_seen = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = mhmq_pkg::REQ_NOP;
		source_index = '0;
		doc_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: error cases on empty, extremes, ties, exhaust last, unused code.
		send_req(mhmq_pkg::REQ_REPLACE, 5'd3, 31'd7);
		send_req(mhmq_pkg::REQ_NOP, 5'd31, '1);
		send_req(mhmq_pkg::REQ_ADD, 5'd31, '1);
		send_req(mhmq_pkg::REQ_ADD, 5'd0, 31'd0);
		send_req(mhmq_pkg::REQ_ADD, 5'd10, 31'd5);
		send_req(mhmq_pkg::REQ_ADD, 5'd11, 31'd5);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd5);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd6);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd0);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, '1);
		send_req(mhmq_pkg::REQ_CLEAR, 5'd0, 31'd0);
		send_req(mhmq_pkg::REQ_ADD, 5'd21, 31'h2aaaaaaa);
		send_req(mhmq_pkg::REQ_ADD, 5'd10, 31'h55555555);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd0);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd0);
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, 31'd0);
		// Fill to the brim in descending order, then overflow twice.
		for (k = 0; k < DEPTH + 2; k++)
			send_req(mhmq_pkg::REQ_ADD, k[4:0], DBITS'(40 - k));
		send_req(mhmq_pkg::REQ_REPLACE, 5'd0, '1);
		send_req(mhmq_pkg::REQ_CLEAR, 5'd0, 31'd0);

		// Hold off until the block has delivered everything owed.
		drain();

		// Random: merge-like flow. Adds and replaces dominate, weighted by fill
		// level so the heap swings between empty and full.
		for (k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM - 200)
				calm_phase = 1'b1;
			if (k == N_RANDOM / 2)
				drain();
			r = $urandom_range(0, 99);
			if (r < 2)
				rq = mhmq_pkg::REQ_CLEAR;
			else if (r < 4)
				rq = mhmq_pkg::REQ_NOP;
			else if (r < 4 + (sb.h_cnt < 16 ? 60 : 35))
				rq = mhmq_pkg::REQ_ADD;
			else
				rq = mhmq_pkg::REQ_REPLACE;
			send_req(rq, SRC_W'($urandom_range(0, 31)), pick_doc());
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests and %0d result words; %0d flagged as ignored.",
			n_sent, sb.words_checked, n_errs_seen);
		if (sb.mismatches == 0 && sb.owed_tops.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Mismatches: %0d, words still owed: %0d", sb.mismatches,
				sb.owed_tops.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
rtl/core/mhmq_pkg.sv
rtl/core/mhmq_fifo.sv
rtl/core/mhmq_engine.sv
rtl/core/min_heap_merge_queue.sv
verif/min_heap_merge_queue_test.sv
